### rtl/gckf_pkg.sv
// Package for the Gray-code-kernel filter step: widths, register indexes,
// reset values and default sizes. Depends on nothing; used by the top level.
`default_nettype none

package gckf_pkg;

  localparam int unsigned PIX_W = 32;

  localparam int unsigned KS_W    = 9;
  localparam int unsigned DELTA_W = 5;
  localparam int unsigned DIM_W   = 11;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZONTAL_MOVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_POSITIVE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS      = 3'd5;

  localparam logic [KS_W-1:0]    KERNEL_SIZE_RST = 9'd4;
  localparam logic [DELTA_W-1:0] DELTA_STEP_RST  = 5'd1;
  localparam logic [DIM_W-1:0]   IMAGE_ROWS_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]   IMAGE_COLS_RST  = 11'd1024;

  localparam int unsigned MAX_ROWS_DEF  = 1024;
  localparam int unsigned MAX_COLS_DEF  = 1024;
  localparam int unsigned MAX_DELTA_DEF = 16;

endpackage

`default_nettype wire

### rtl/gray_code_kernel_filter_step.sv
// Top level of the Gray-code-kernel filter step: delay stores, position
// counters, configuration registers and the two-stage datapath. Uses gckf_pkg.
`default_nettype none

// The block takes one pixel word per cycle and gives one result word per cycle
// unless the output stalls, via the compute and result registers. The rate is
// set by the single read port and single write port of each delay store: the
// delayed words are read when a word is accepted and the new words are
// written when the result leaves the compute stage, with a bypass for a distance
// of one word. The stores are not cleared after reset; a wrap flag and the store
// pointer tell which slots were never written, and those read as zero.
module gray_code_kernel_filter_step
  import gckf_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS  = MAX_COLS_DEF,
  parameter int unsigned MAX_DELTA = MAX_DELTA_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic signed [PIX_W-1:0] pixel_in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [PIX_W-1:0]    pixel_out_o,
  output logic                       last_pixel_o
);

  localparam int unsigned DEPTH  = MAX_DELTA * MAX_ROWS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned DW     = $clog2(DEPTH + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned COL_W  = $clog2(MAX_COLS);
  localparam int unsigned RCW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned DLW    = $clog2(MAX_DELTA + 1);
  localparam int unsigned DCW    = (DLW > DELTA_W) ? DLW : DELTA_W;
  localparam int unsigned DIM_A  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned DIM_B  = (DIM_A > 2047) ? DIM_A : 2047;
  localparam int unsigned CW     = $clog2(DIM_B + 512 + 1);
  localparam int unsigned PW     = DLW + RCW;

  localparam logic [CW-1:0]  MAX_ROWS_C  = CW'(MAX_ROWS);
  localparam logic [CW-1:0]  MAX_COLS_C  = CW'(MAX_COLS);
  localparam logic [CW-1:0]  ONE_C       = CW'(1);
  localparam logic [DCW-1:0] MAX_DELTA_C = DCW'(MAX_DELTA);
  localparam logic [DW:0]    DEPTH_X     = (DW + 1)'(DEPTH);
  localparam logic [AW-1:0]  LAST_SLOT   = AW'(DEPTH - 1);

  // Configuration registers.
  logic [KS_W-1:0]    kernel_size_q;
  logic [DELTA_W-1:0] delta_step_q;
  logic               horizontal_move_q;
  logic               alpha_positive_q;
  logic [DIM_W-1:0]   image_rows_q;
  logic [DIM_W-1:0]   image_cols_q;

  logic cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_size_q     <= KERNEL_SIZE_RST;
      delta_step_q      <= DELTA_STEP_RST;
      horizontal_move_q <= 1'b1;
      alpha_positive_q  <= 1'b1;
      image_rows_q      <= IMAGE_ROWS_RST;
      image_cols_q      <= IMAGE_COLS_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_KERNEL_SIZE:     kernel_size_q     <= cfg_data_i[KS_W-1:0];
        CFG_DELTA_STEP:      delta_step_q      <= cfg_data_i[DELTA_W-1:0];
        CFG_HORIZONTAL_MOVE: horizontal_move_q <= cfg_data_i[0];
        CFG_ALPHA_POSITIVE:  alpha_positive_q  <= cfg_data_i[0];
        CFG_IMAGE_ROWS:      image_rows_q      <= cfg_data_i[DIM_W-1:0];
        CFG_IMAGE_COLS:      image_cols_q      <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_move;
  logic in_fire;

  assign s1_move    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_move;
  assign in_fire    = in_valid_i & in_ready_o;

  // Position and store pointer state.
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic             wrapped_q;

  // Effective dimensions and delay distance.
  logic [CW-1:0]  rows_raw, cols_raw, rows_c, cols_c, ks_c, row_c, col_c;
  logic [DCW-1:0] delta_raw;
  logic [DLW-1:0] delta_c;
  logic [PW-1:0]  dist_prod;
  logic [DW-1:0]  reach;
  logic [DW-1:0]  ptr_ext;
  logic           dist_le;
  logic [DW:0]    rd_sum;
  logic [AW-1:0]  rd_addr;
  logic           active_d;
  logic           last_d;
  logic [CW-1:0]  row_inc, col_inc;

  always_comb begin
    rows_raw = CW'(image_rows_q);
    cols_raw = CW'(image_cols_q);
    if (rows_raw == '0) begin
      rows_c = ONE_C;
    end else if (rows_raw > MAX_ROWS_C) begin
      rows_c = MAX_ROWS_C;
    end else begin
      rows_c = rows_raw;
    end
    if (cols_raw == '0) begin
      cols_c = ONE_C;
    end else if (cols_raw > MAX_COLS_C) begin
      cols_c = MAX_COLS_C;
    end else begin
      cols_c = cols_raw;
    end

    delta_raw = DCW'(delta_step_q);
    delta_c   = (delta_raw > MAX_DELTA_C) ? MAX_DELTA_C[DLW-1:0] : delta_raw[DLW-1:0];
    dist_prod = PW'(delta_c) * PW'(rows_c[RCW-1:0]);
    reach     = horizontal_move_q ? dist_prod[DW-1:0] : DW'(delta_c);

    ptr_ext = DW'(ptr_q);
    dist_le = reach <= ptr_ext;
    rd_sum  = (DW + 1)'(ptr_q) + (dist_le ? '0 : DEPTH_X) - (DW + 1)'(reach);
    rd_addr = rd_sum[AW-1:0];

    ks_c  = CW'(kernel_size_q);
    row_c = CW'(row_q);
    col_c = CW'(col_q);
    if (horizontal_move_q) begin
      active_d = (row_c >= ONE_C) && (row_c < rows_c) &&
                 (col_c >= ks_c) && ((col_c + ks_c) < cols_c);
    end else begin
      active_d = (row_c >= ks_c) && ((row_c + ks_c) < rows_c) &&
                 (col_c >= ONE_C) && (col_c < cols_c);
    end

    row_inc = row_c + ONE_C;
    col_inc = col_c + ONE_C;
    last_d  = (row_inc >= rows_c) && (col_inc >= cols_c);
    if (row_inc >= rows_c) begin
      row_d = '0;
      col_d = (col_inc >= cols_c) ? '0 : col_inc[COL_W-1:0];
    end else begin
      row_d = row_inc[ROW_W-1:0];
      col_d = col_q;
    end
    ptr_d = (ptr_q == LAST_SLOT) ? '0 : ptr_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
    end else if (in_fire) begin
      row_q <= row_d;
      col_q <= col_d;
      ptr_q <= ptr_d;
      if (ptr_q == LAST_SLOT) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // Delay stores.
  logic [PIX_W-1:0] in_store  [DEPTH];
  logic [PIX_W-1:0] out_store [DEPTH];
  logic [PIX_W-1:0] rd_in_q, rd_out_q;

  // Compute stage.
  logic signed [PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]           s1_ptr_q;
  logic                    s1_active_q, s1_alpha_q, s1_dzero_q, s1_old_ok_q;
  logic                    s1_fwd_q, s1_last_q;
  logic [PIX_W-1:0]        s1_fwd_in_q, s1_fwd_out_q;
  logic [PIX_W-1:0]        prev_in, prev_out, result;

  always_comb begin
    if (s1_dzero_q) begin
      prev_in  = s1_pix_q;
      prev_out = '0;
    end else if (!s1_old_ok_q) begin
      prev_in  = '0;
      prev_out = '0;
    end else if (s1_fwd_q) begin
      prev_in  = s1_fwd_in_q;
      prev_out = s1_fwd_out_q;
    end else begin
      prev_in  = rd_in_q;
      prev_out = rd_out_q;
    end
    if (!s1_active_q) begin
      result = '0;
    end else if (s1_alpha_q) begin
      result = s1_pix_q + prev_in + prev_out;
    end else begin
      result = s1_pix_q - prev_in - prev_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_in_q  <= in_store[rd_addr];
      rd_out_q <= out_store[rd_addr];
    end
    if (s1_move) begin
      in_store[s1_ptr_q]  <= s1_pix_q;
      out_store[s1_ptr_q] <= result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q     <= pixel_in_i;
      s1_ptr_q     <= ptr_q;
      s1_active_q  <= active_d;
      s1_alpha_q   <= alpha_positive_q;
      s1_dzero_q   <= (reach == '0);
      s1_old_ok_q  <= wrapped_q | dist_le;
      s1_last_q    <= last_d;
      s1_fwd_q     <= s1_move && (s1_ptr_q == rd_addr);
      s1_fwd_in_q  <= s1_pix_q;
      s1_fwd_out_q <= result;
    end
  end

  // Result register.
  logic signed [PIX_W-1:0] pixel_out_q;
  logic                    last_pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      pixel_out_q  <= result;
      last_pixel_q <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign last_pixel_o = last_pixel_q;

endmodule

`default_nettype wire
